@@ rtl/assert_macros.svh @@
// assertion macros shared by the ring message queue rtl
// expects clk and rst_n in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define RMQ_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rmq assertion failed");

// next-cycle implication, checked outside reset
`define RMQ_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rmq assertion failed");

`endif

@@ rtl/rmq_pkg.sv @@
// types, codes and sizes for the ring message queue
// no dependencies
package rmq_pkg;

    localparam int BUF_BYTES = 4096;
    localparam int HDR_BYTES = 4;

    // header bytes that carry id and length
    localparam int HDR_USED = (HDR_BYTES < 4) ? HDR_BYTES : 4;

    localparam int POS_W = $clog2(BUF_BYTES);
    localparam int CNT_W = $clog2(BUF_BYTES + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int MSG_W = $clog2(BUF_BYTES / HDR_BYTES + 1);
    localparam int K_W   = $clog2(HDR_BYTES + 1);

    typedef enum logic [2:0] {
        CMD_OPEN_WR  = 3'd0,
        CMD_WR_BYTE  = 3'd1,
        CMD_CLOSE_WR = 3'd2,
        CMD_OPEN_RD  = 3'd3,
        CMD_RD_BYTE  = 3'd4,
        CMD_CLOSE_RD = 3'd5
    } cmd_e;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOSPACE   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOPAYLOAD = 3'd3,
        ST_ORDER     = 3'd4
    } status_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WHDR,
        S_WLEN,
        S_RHDR,
        S_RFIN,
        S_RBYTE
    } state_e;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] message_id;
        logic [7:0]  data_in;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  data_out;
        logic [15:0] id_out;
        logic [12:0] payload_left;
        logic [12:0] free_space;
    } out_t;

    typedef struct packed {
        logic             en;
        logic             we;
        logic [POS_W-1:0] addr;
        logic [7:0]       wdata;
    } mem_req_t;

    typedef struct packed {
        logic valid;
        out_t item;
    } res_t;

endpackage

@@ rtl/rmq_ring_ram.sv @@
// generic single-port synchronous ram, registered read data
// no dependencies
module rmq_ring_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

@@ rtl/rmq_ctrl.sv @@
// command sequencer and queue state of the ring message queue
// depends on rmq_pkg and assert_macros.svh
`include "assert_macros.svh"

module rmq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  rmq_pkg::in_t      req_data,
    input  logic              out_free,
    output rmq_pkg::res_t     res,
    output rmq_pkg::mem_req_t mem_req,
    input  logic [7:0]        mem_rdata
);
    import rmq_pkg::*;

    localparam logic [SUM_W-1:0] BUF_SUM = SUM_W'(BUF_BYTES);
    localparam logic [SUM_W-1:0] HDR_SUM = SUM_W'(HDR_BYTES);
    localparam logic [CNT_W-1:0] BUF_CNT = CNT_W'(BUF_BYTES);
    localparam logic [CNT_W-1:0] HDR_CNT = CNT_W'(HDR_BYTES);
    localparam logic [MSG_W-1:0] MSG_MAX = MSG_W'(BUF_BYTES / HDR_BYTES);
    localparam logic [K_W-1:0]   K_HDR_LAST = K_W'(HDR_BYTES - 1);
    localparam logic [K_W-1:0]   K_USED_LAST = K_W'(HDR_USED - 1);
    localparam int               HDR_SHIFT = 8 * (4 - HDR_USED);

    function automatic logic [POS_W-1:0] wrap_add(logic [POS_W-1:0] p, logic [CNT_W-1:0] n);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p) + SUM_W'(n);
        if (s >= BUF_SUM)
        begin
            s = s - BUF_SUM;
        end
        return POS_W'(s);
    endfunction

    state_e           state_reg, state_next;
    in_t              req_reg, req_next;
    logic [POS_W-1:0] wpos_reg, wpos_next;
    logic [POS_W-1:0] rpos_reg, rpos_next;
    logic [CNT_W-1:0] wfree_reg, wfree_next;
    logic [CNT_W-1:0] rrem_reg, rrem_next;
    logic [POS_W-1:0] hdr_at_reg, hdr_at_next;
    logic [CNT_W-1:0] olen_reg, olen_next;
    logic             wopen_reg, wopen_next;
    logic             ropen_reg, ropen_next;
    logic [MSG_W-1:0] msgs_reg, msgs_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [23:0]      hsh_reg, hsh_next;

    logic [SUM_W-1:0] wsum;
    logic             wcross;
    logic             rcross;
    logic [SUM_W-1:0] need;
    logic [POS_W-1:0] wh;
    status_e          ex_status;
    logic             ex_ok;
    logic [15:0]      olen16;
    logic [31:0]      hdr_word;

    // decision for the request held in req_reg
    always_comb
    begin
        wsum   = SUM_W'(wpos_reg) + HDR_SUM;
        wcross = wsum > BUF_SUM;
        need   = wcross ? (BUF_SUM - SUM_W'(wpos_reg) + HDR_SUM) : HDR_SUM;
        wh     = wcross ? '0 : wpos_reg;
        rcross = (SUM_W'(rpos_reg) + HDR_SUM) > BUF_SUM;
        ex_status = ST_OK;
        unique case (req_reg.cmd)
            CMD_OPEN_WR:
            begin
                if (wopen_reg)
                    ex_status = ST_ORDER;
                else if (SUM_W'(wfree_reg) < need)
                    ex_status = ST_NOSPACE;
            end
            CMD_WR_BYTE:
            begin
                if (!wopen_reg)
                    ex_status = ST_ORDER;
                else if (wfree_reg == '0)
                    ex_status = ST_NOSPACE;
            end
            CMD_CLOSE_WR:
            begin
                if (!wopen_reg)
                    ex_status = ST_ORDER;
            end
            CMD_OPEN_RD:
            begin
                if (ropen_reg)
                    ex_status = ST_ORDER;
                else if (msgs_reg == '0)
                    ex_status = ST_EMPTY;
            end
            CMD_RD_BYTE:
            begin
                if (!ropen_reg)
                    ex_status = ST_ORDER;
                else if (rrem_reg == '0)
                    ex_status = ST_NOPAYLOAD;
            end
            CMD_CLOSE_RD:
            begin
                if (!ropen_reg)
                    ex_status = ST_ORDER;
            end
            default:
            begin
                ex_status = ST_ORDER;
            end
        endcase
        ex_ok    = ex_status == ST_OK;
        olen16   = 16'(olen_reg);
        hdr_word = {mem_rdata, hsh_reg} >> HDR_SHIFT;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (ex_ok)
                    begin
                        unique case (req_reg.cmd)
                            CMD_OPEN_WR:  state_next = S_WHDR;
                            CMD_CLOSE_WR: state_next = (HDR_BYTES > 2) ? S_WLEN : S_IDLE;
                            CMD_OPEN_RD:  state_next = S_RHDR;
                            CMD_RD_BYTE:  state_next = S_RBYTE;
                            default:      state_next = S_IDLE;
                        endcase
                    end
                end
            end
            S_WHDR:
            begin
                if (k_reg == K_HDR_LAST)
                    state_next = S_IDLE;
            end
            S_WLEN:
            begin
                if (k_reg == K_USED_LAST)
                    state_next = S_IDLE;
            end
            S_RHDR:
            begin
                if (k_reg == K_USED_LAST)
                    state_next = S_RFIN;
            end
            S_RFIN:  state_next = S_IDLE;
            S_RBYTE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath, memory requests and result
    always_comb
    begin
        req_next    = req_reg;
        wpos_next   = wpos_reg;
        rpos_next   = rpos_reg;
        wfree_next  = wfree_reg;
        rrem_next   = rrem_reg;
        hdr_at_next = hdr_at_reg;
        olen_next   = olen_reg;
        wopen_next  = wopen_reg;
        ropen_next  = ropen_reg;
        msgs_next   = msgs_reg;
        k_next      = k_reg;
        hsh_next    = hsh_reg;
        mem_req     = '0;
        res.valid         = 1'b0;
        res.item.status   = ST_OK;
        res.item.data_out = '0;
        res.item.id_out   = '0;
        req_ready = state_reg == S_IDLE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    req_next = req_data;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    res.item.status = ex_status;
                    if (!ex_ok)
                    begin
                        res.valid = 1'b1;
                    end
                    else
                    begin
                        unique case (req_reg.cmd)
                            CMD_OPEN_WR:
                            begin
                                wfree_next  = CNT_W'(SUM_W'(wfree_reg) - need);
                                hdr_at_next = wh;
                                olen_next   = '0;
                                wpos_next   = wrap_add(wh, HDR_CNT);
                                wopen_next  = 1'b1;
                                k_next      = '0;
                            end
                            CMD_WR_BYTE:
                            begin
                                mem_req.en    = 1'b1;
                                mem_req.we    = 1'b1;
                                mem_req.addr  = wpos_reg;
                                mem_req.wdata = req_reg.data_in;
                                wpos_next  = wrap_add(wpos_reg, CNT_W'(1));
                                wfree_next = wfree_reg - CNT_W'(1);
                                olen_next  = olen_reg + CNT_W'(1);
                                res.valid  = 1'b1;
                            end
                            CMD_CLOSE_WR:
                            begin
                                if (HDR_BYTES > 2)
                                begin
                                    k_next = K_W'(2);
                                end
                                else
                                begin
                                    msgs_next  = msgs_reg + MSG_W'(1);
                                    wopen_next = 1'b0;
                                    res.valid  = 1'b1;
                                end
                            end
                            CMD_OPEN_RD:
                            begin
                                // header would cross the end: reader skips the tail too
                                if (rcross)
                                begin
                                    wfree_next = CNT_W'(SUM_W'(wfree_reg) + BUF_SUM
                                                        - SUM_W'(rpos_reg));
                                    rpos_next  = '0;
                                end
                                k_next = '0;
                            end
                            CMD_RD_BYTE:
                            begin
                                mem_req.en   = 1'b1;
                                mem_req.addr = rpos_reg;
                            end
                            CMD_CLOSE_RD:
                            begin
                                rpos_next  = wrap_add(rpos_reg, rrem_reg);
                                wfree_next = wfree_reg + rrem_reg;
                                rrem_next  = '0;
                                ropen_next = 1'b0;
                                res.valid  = 1'b1;
                            end
                            default:
                            begin
                                res.valid = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_WHDR:
            begin
                mem_req.en   = 1'b1;
                mem_req.we   = 1'b1;
                mem_req.addr = POS_W'(hdr_at_reg + POS_W'(k_reg));
                if (k_reg == K_W'(0))
                    mem_req.wdata = req_reg.message_id[7:0];
                else if (k_reg == K_W'(1))
                    mem_req.wdata = req_reg.message_id[15:8];
                else
                    mem_req.wdata = 8'h00;
                k_next = k_reg + K_W'(1);
                if (k_reg == K_HDR_LAST)
                    res.valid = 1'b1;
            end
            S_WLEN:
            begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = POS_W'(hdr_at_reg + POS_W'(k_reg));
                mem_req.wdata = (k_reg == K_W'(2)) ? olen16[7:0] : olen16[15:8];
                k_next = k_reg + K_W'(1);
                if (k_reg == K_USED_LAST)
                begin
                    msgs_next  = msgs_reg + MSG_W'(1);
                    wopen_next = 1'b0;
                    res.valid  = 1'b1;
                end
            end
            S_RHDR:
            begin
                mem_req.en   = 1'b1;
                mem_req.addr = POS_W'(rpos_reg + POS_W'(k_reg));
                if (k_reg != K_W'(0))
                    hsh_next = {mem_rdata, hsh_reg[23:8]};
                k_next = k_reg + K_W'(1);
            end
            S_RFIN:
            begin
                res.item.id_out = hdr_word[15:0];
                rrem_next  = CNT_W'(hdr_word[31:16]);
                rpos_next  = wrap_add(rpos_reg, HDR_CNT);
                wfree_next = wfree_reg + HDR_CNT;
                msgs_next  = msgs_reg - MSG_W'(1);
                ropen_next = 1'b1;
                res.valid  = 1'b1;
            end
            S_RBYTE:
            begin
                res.item.data_out = mem_rdata;
                rpos_next  = wrap_add(rpos_reg, CNT_W'(1));
                rrem_next  = rrem_reg - CNT_W'(1);
                wfree_next = wfree_reg + CNT_W'(1);
                res.valid  = 1'b1;
            end
            default:
            begin
                req_next = req_reg;
            end
        endcase

        res.item.payload_left = 13'(rrem_next);
        res.item.free_space   = 13'(wfree_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wpos_reg   <= '0;
            rpos_reg   <= '0;
            wfree_reg  <= BUF_CNT;
            rrem_reg   <= '0;
            hdr_at_reg <= '0;
            olen_reg   <= '0;
            wopen_reg  <= 1'b0;
            ropen_reg  <= 1'b0;
            msgs_reg   <= '0;
            k_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wpos_reg   <= wpos_next;
            rpos_reg   <= rpos_next;
            wfree_reg  <= wfree_next;
            rrem_reg   <= rrem_next;
            hdr_at_reg <= hdr_at_next;
            olen_reg   <= olen_next;
            wopen_reg  <= wopen_next;
            ropen_reg  <= ropen_next;
            msgs_reg   <= msgs_next;
            k_reg      <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        hsh_reg <= hsh_next;
    end

    `RMQ_ASSERT_IMP(a_res_has_slot, res.valid, out_free)
    `RMQ_ASSERT_IMP(a_free_bound, 1'b1, wfree_reg <= BUF_CNT)
    `RMQ_ASSERT_IMP(a_msgs_bound, 1'b1, msgs_reg <= MSG_MAX)
    `RMQ_ASSERT_NXT(a_byte_read_lands, (state_reg == S_EXEC) && mem_req.en && !mem_req.we, state_reg == S_RBYTE)

endmodule

@@ rtl/ring_message_queue_core.sv @@
// top level of the ring message queue: sequencer, byte ring and result register
// depends on rmq_pkg, rmq_ctrl and rmq_ring_ram
//
// channel    | handshake                | payload
// -----------+--------------------------+---------------------------
// request    | req_valid / req_ready    | req_data (rmq_pkg::in_t)
// response   | rsp_valid / rsp_ready    | rsp_data (rmq_pkg::out_t)
//
// every request gives exactly one response
// request steps are set by the single port of the byte ring, one access a cycle:
// read byte reads the ring and then returns the byte, open write writes each header
// byte, close write the length bytes, open read reads the header bytes in turn
// a request is taken whenever the sequencer is idle, even while a response waits
// the sequencer holds before its first step until the result register is free
// asynchronous active-low reset clears all counters and flags; ring contents are
// undefined until written and need no clearing
module ring_message_queue_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rmq_pkg::in_t  req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rmq_pkg::out_t rsp_data
);
    import rmq_pkg::*;

    res_t       res;
    mem_req_t   mem_req;
    logic [7:0] mem_rdata;
    logic       out_free;
    logic       rsp_valid_reg;
    out_t       rsp_data_reg;

    // result register is free when empty or being drained this cycle
    assign out_free = !rsp_valid_reg || rsp_ready;

    rmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .out_free  (out_free),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // byte ring; the sequencer never reads and writes in the same cycle,
    // so a read always sees every earlier write
    rmq_ring_ram #(
        .DATA_W (8),
        .DEPTH  (BUF_BYTES),
        .ADDR_W (POS_W)
    ) u_ring (
        .clk   (clk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

    // output register between the sequencer and the response channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            rsp_data_reg <= res.item;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule
